### design/assert_macros.svh
// Assertion macros shared by the window averager RTL.
// Depends on clk and arst_n being visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### design/mcwa_pkg.sv
// Shared types and constants of the multichannel window averager.
// No dependencies; used by mcwa_div and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mcwa_pkg;

	// Default configuration
	localparam int NUM_CHANNELS_DEF = 16;
	localparam int WINDOW_DEF       = 10;

	// Field widths
	localparam int CH_FIELD_W = 8;
	localparam int TYPE_W     = 8;
	localparam int KIND_W     = 8;
	localparam int VAL_W      = 64;
	localparam int POS_W      = 4;
	localparam int FILL_W     = 4;

	// Divider: quotient bits retired per cycle and its step counter
	localparam int DIV_BITS  = 8;
	localparam int DIV_STEPS = VAL_W / DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// Query kinds
	localparam logic [KIND_W-1:0] KIND_LATEST  = 8'd0;
	localparam logic [KIND_W-1:0] KIND_AVERAGE = 8'd1;

	// Per-channel state entry
	typedef struct packed {
		logic [POS_W-1:0]  wpos;
		logic [FILL_W-1:0] fill;
		logic [VAL_W-1:0]  sum;
		logic [TYPE_W-1:0] vtype;
	} chan_state_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHAN,
		ST_SAMP,
		ST_DIV
	} seq_state_t;

endpackage

`default_nettype wire

### design/mcwa_div.sv
// Iterative divider of a 64-bit sum by a 4-bit fill count, 8 quotient bits a cycle.
// Depends on mcwa_pkg for widths and step count.
`timescale 1ns / 1ps
`default_nettype none

module mcwa_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [mcwa_pkg::VAL_W-1:0]   dividend,
	input  wire logic [mcwa_pkg::FILL_W-1:0]  divisor,
	output logic                              done,
	output logic [mcwa_pkg::VAL_W-1:0]        quotient
);

	logic                             busy_q;
	logic                             done_q;
	logic [mcwa_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [mcwa_pkg::VAL_W-1:0]       quo_q;
	logic [mcwa_pkg::FILL_W-1:0]      rem_q;
	logic [mcwa_pkg::FILL_W-1:0]      dvs_q;
	logic [mcwa_pkg::VAL_W-1:0]       quo_d;
	logic [mcwa_pkg::FILL_W-1:0]      rem_d;

	// Retire DIV_BITS quotient bits by restoring steps on a narrow remainder
	always_comb begin
		logic [mcwa_pkg::FILL_W:0] r5;
		logic                      ge;
		quo_d = quo_q;
		rem_d = rem_q;
		for (int i = 0; i < mcwa_pkg::DIV_BITS; i++) begin
			r5    = {rem_d, quo_d[mcwa_pkg::VAL_W-1]};
			ge    = (r5 >= {1'b0, dvs_q});
			quo_d = {quo_d[mcwa_pkg::VAL_W-2:0], ge};
			rem_d = ge ? mcwa_pkg::FILL_W'(r5 - {1'b0, dvs_q}) : r5[mcwa_pkg::FILL_W-1:0];
		end
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {mcwa_pkg::DIV_CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
				end
			end
			// flag the cycle after the last step
			done_q <= !start && busy_q && (cnt_q == {mcwa_pkg::DIV_CNT_W{1'b1}});
		end
	end

	// Datapath: load operands, then advance one step a cycle while busy
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### design/multichannel_window_averager_top.sv
// Top level of the multichannel window averager: request sequencer,
// per-channel state memory and sample memory. Depends on mcwa_pkg, mcwa_div
// and assert_macros.svh.
//
// Throughput: one request at a time; an in-range sample visits ST_CHAN and
// ST_SAMP. The result strobe follows ST_CHAN for out-of-range, empty or
// unknown-kind queries, ST_SAMP for a latest-sample query (sample memory
// read) and ST_DIV for an average query (divider). busy is high meanwhile.
// Reset clears the channel valid bits, so every channel reads as empty and
// typeless; the sample memory is not cleared. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module multichannel_window_averager_top #(
	parameter int NUM_CHANNELS = mcwa_pkg::NUM_CHANNELS_DEF,
	parameter int WINDOW       = mcwa_pkg::WINDOW_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              operation,
	input  wire logic [mcwa_pkg::CH_FIELD_W-1:0]   channel,
	input  wire logic [mcwa_pkg::TYPE_W-1:0]       sample_type,
	input  wire logic [mcwa_pkg::VAL_W-1:0]        sample_value,
	input  wire logic [mcwa_pkg::KIND_W-1:0]       query_kind,
	output logic                                   result_valid,
	output logic [mcwa_pkg::CH_FIELD_W-1:0]        result_channel,
	output logic [mcwa_pkg::TYPE_W-1:0]            result_type,
	output logic [mcwa_pkg::VAL_W-1:0]             result_value
);

	localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SLOTS   = NUM_CHANNELS * WINDOW;
	localparam int SA_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [mcwa_pkg::POS_W-1:0]  WIN_POS  = mcwa_pkg::POS_W'(WINDOW);
	localparam logic [mcwa_pkg::POS_W-1:0]  LAST_POS = mcwa_pkg::POS_W'(WINDOW - 1);
	localparam logic [mcwa_pkg::FILL_W-1:0] WIN_FILL = mcwa_pkg::FILL_W'(WINDOW);
	localparam logic [mcwa_pkg::CH_FIELD_W:0] CH_LIMIT =
		(mcwa_pkg::CH_FIELD_W + 1)'(NUM_CHANNELS);

	// Sequencer and latched request
	mcwa_pkg::seq_state_t                state_q, state_d;
	logic                                accept;
	logic                                op_q;
	logic [mcwa_pkg::CH_FIELD_W-1:0]     channel_q;
	logic [mcwa_pkg::TYPE_W-1:0]         vtype_q;
	logic [mcwa_pkg::VAL_W-1:0]          value_q;
	logic [mcwa_pkg::KIND_W-1:0]         kind_q;
	logic                                in_range;
	logic [CH_W-1:0]                     ch_idx;

	// Per-channel state memory with reset-cleared valid bits
	mcwa_pkg::chan_state_t               chan_mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]             chan_valid_q;
	mcwa_pkg::chan_state_t               chan_rd_s1;
	logic                                valid_s1;
	mcwa_pkg::chan_state_t               cur;
	logic                                chan_wr_en;
	mcwa_pkg::chan_state_t               chan_wr_data;

	// Sample memory
	logic [mcwa_pkg::VAL_W-1:0]          smp_mem [SLOTS];
	logic [mcwa_pkg::VAL_W-1:0]          smp_rd_s2;
	logic                                smp_rd_en;
	logic                                smp_wr_en;
	logic [SA_W-1:0]                     smp_addr_d;
	logic [SA_W-1:0]                     smp_addr_q;
	logic [mcwa_pkg::POS_W-1:0]          prev_pos;
	logic [mcwa_pkg::POS_W-1:0]          next_pos;
	logic                                full;

	// Divider and result
	logic                                div_start;
	logic                                div_done;
	logic [mcwa_pkg::VAL_W-1:0]          div_quotient;
	logic                                out_load;
	logic [mcwa_pkg::TYPE_W-1:0]         out_type_d;
	logic [mcwa_pkg::VAL_W-1:0]          out_value_d;
	logic                                result_valid_q;
	logic [mcwa_pkg::CH_FIELD_W-1:0]     result_channel_q;
	logic [mcwa_pkg::TYPE_W-1:0]         result_type_q;
	logic [mcwa_pkg::VAL_W-1:0]          result_value_q;

	assign accept   = start && (state_q == mcwa_pkg::ST_IDLE);
	assign busy     = (state_q != mcwa_pkg::ST_IDLE);
	assign in_range = ({1'b0, channel_q} < CH_LIMIT);
	assign ch_idx   = channel_q[CH_W-1:0];
	assign cur      = valid_s1 ? chan_rd_s1 : '0;
	assign full     = (cur.fill == WIN_FILL);
	assign prev_pos = (cur.wpos == '0) ? LAST_POS : cur.wpos - 1'b1;
	assign next_pos = (cur.wpos + 1'b1 == WIN_POS) ? '0 : cur.wpos + 1'b1;

	// Latch the request on acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= operation;
			channel_q <= channel;
			vtype_q   <= sample_type;
			value_q   <= sample_value;
			kind_q    <= query_kind;
		end
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcwa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory controls and result selection
	always_comb begin
		state_d      = state_q;
		smp_rd_en    = 1'b0;
		smp_wr_en    = 1'b0;
		smp_addr_d   = SA_W'(ch_idx * WINDOW + cur.wpos);
		chan_wr_en   = 1'b0;
		chan_wr_data = cur;
		div_start    = 1'b0;
		out_load     = 1'b0;
		out_type_d   = in_range ? cur.vtype : '0;
		out_value_d  = '0;
		case (state_q)
			mcwa_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = mcwa_pkg::ST_CHAN;
				end
			end
			mcwa_pkg::ST_CHAN: begin
				if (op_q == mcwa_pkg::OP_SAMPLE) begin
					// fetch the slot to be evicted; drop out-of-range samples
					smp_rd_en = in_range;
					state_d   = in_range ? mcwa_pkg::ST_SAMP : mcwa_pkg::ST_IDLE;
				end else if (!in_range || cur.fill == '0 ||
						(kind_q != mcwa_pkg::KIND_LATEST &&
						kind_q != mcwa_pkg::KIND_AVERAGE)) begin
					out_load = 1'b1;
					state_d  = mcwa_pkg::ST_IDLE;
				end else if (kind_q == mcwa_pkg::KIND_LATEST) begin
					smp_rd_en  = 1'b1;
					smp_addr_d = SA_W'(ch_idx * WINDOW + prev_pos);
					state_d    = mcwa_pkg::ST_SAMP;
				end else begin
					div_start = 1'b1;
					state_d   = mcwa_pkg::ST_DIV;
				end
			end
			mcwa_pkg::ST_SAMP: begin
				if (op_q == mcwa_pkg::OP_SAMPLE) begin
					// write back the sample and the updated channel entry
					smp_wr_en          = 1'b1;
					chan_wr_en         = 1'b1;
					chan_wr_data.vtype = vtype_q;
					chan_wr_data.wpos  = next_pos;
					chan_wr_data.fill  = full ? cur.fill : cur.fill + 1'b1;
					chan_wr_data.sum   = cur.sum - (full ? smp_rd_s2 : '0) + value_q;
				end else begin
					out_load    = 1'b1;
					out_value_d = smp_rd_s2;
				end
				state_d = mcwa_pkg::ST_IDLE;
			end
			mcwa_pkg::ST_DIV: begin
				if (div_done) begin
					out_load    = 1'b1;
					out_value_d = div_quotient;
					state_d     = mcwa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mcwa_pkg::ST_IDLE;
			end
		endcase
	end

	// Channel memory: read on acceptance, write back after a sample
	always_ff @(posedge clk) begin
		if (accept) begin
			chan_rd_s1 <= chan_mem[channel[CH_W-1:0]];
		end
		if (chan_wr_en) begin
			chan_mem[ch_idx] <= chan_wr_data;
		end
	end

	// Channel valid bits: clear at reset, set on the first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_valid_q <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= chan_valid_q[channel[CH_W-1:0]];
			end
			if (chan_wr_en) begin
				chan_valid_q[ch_idx] <= 1'b1;
			end
		end
	end

	// Sample memory: one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (smp_rd_en) begin
			smp_rd_s2  <= smp_mem[smp_addr_d];
			smp_addr_q <= smp_addr_d;
		end
		if (smp_wr_en) begin
			smp_mem[smp_addr_q] <= value_q;
		end
	end

	mcwa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cur.sum),
		.divisor  (cur.fill),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= out_load;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			result_channel_q <= channel_q;
			result_type_q    <= out_type_d;
			result_value_q   <= out_value_d;
		end
	end

	assign result_valid   = result_valid_q;
	assign result_channel = result_channel_q;
	assign result_type    = result_type_q;
	assign result_value   = result_value_q;

	`ASSERT_CLK(a_single_strobe, result_valid |=> !result_valid, "result strobe lasted two cycles")
	`ASSERT_CLK(a_div_query, (state_q == mcwa_pkg::ST_DIV) |-> (op_q == mcwa_pkg::OP_QUERY && cur.fill != '0), "divide without a nonempty query")
	`ASSERT_CLK(a_write_in_range, chan_wr_en |-> (in_range && op_q == mcwa_pkg::OP_SAMPLE), "channel write without an in-range sample")
	`ASSERT_NEVER(a_busy_strobe, out_load && state_q == mcwa_pkg::ST_IDLE, "result loaded while idle")

endmodule

`default_nettype wire
